[rtl/s2i_pkg.sv]
// s2i_pkg: shared constants, phase type and character helpers for the string to integer parser
// depends on nothing; used by s2i_accum, s2i_core, the top level and the test bench

package s2i_pkg;

  // default widths handed to the top level parameters
  localparam int unsigned ValueBitsDef    = 32;
  localparam int unsigned PositionBitsDef = 16;

  // fixed field widths
  localparam int unsigned CharBits = 8;
  localparam int unsigned BaseBits = 6;

  // parse phases, one-hot
  typedef enum logic [3:0] {
    PhSpace  = 4'b0001,
    PhSigned = 4'b0010,
    PhZero   = 4'b0100,
    PhDigits = 4'b1000
  } phase_e;

  // character codes
  localparam logic [CharBits-1:0] CharMinus = 8'h2D;
  localparam logic [CharBits-1:0] CharPlus  = 8'h2B;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharNine  = 8'h39;
  localparam logic [CharBits-1:0] CharUpA   = 8'h41;
  localparam logic [CharBits-1:0] CharUpZ   = 8'h5A;
  localparam logic [CharBits-1:0] CharLowA  = 8'h61;
  localparam logic [CharBits-1:0] CharLowZ  = 8'h7A;
  localparam logic [CharBits-1:0] CharLowX  = 8'h78;
  localparam logic [CharBits-1:0] CharUpX   = 8'h58;
  localparam logic [CharBits-1:0] CharLowB  = 8'h62;
  localparam logic [CharBits-1:0] CharUpB   = 8'h42;
  localparam logic [CharBits-1:0] CharSpace = 8'h20;
  localparam logic [CharBits-1:0] CharTab   = 8'h09;
  localparam logic [CharBits-1:0] CharCr    = 8'h0D;

  // letter offsets: 'A' - 10 and 'a' - 10
  localparam logic [CharBits-1:0] LetterUpOfs  = 8'd55;
  localparam logic [CharBits-1:0] LetterLowOfs = 8'd87;

  // radix codes
  localparam logic [BaseBits-1:0] BaseAuto = 6'd0;
  localparam logic [BaseBits-1:0] BaseBin  = 6'd2;
  localparam logic [BaseBits-1:0] BaseOct  = 6'd8;
  localparam logic [BaseBits-1:0] BaseDec  = 6'd10;
  localparam logic [BaseBits-1:0] BaseHex  = 6'd16;

  function automatic logic is_space(input logic [CharBits-1:0] ch);
    return ch inside {CharSpace, [CharTab:CharCr]};
  endfunction

  function automatic logic is_alnum(input logic [CharBits-1:0] ch);
    return ch inside {[CharZero:CharNine], [CharUpA:CharUpZ], [CharLowA:CharLowZ]};
  endfunction

  // digit value 0 to 35; meaningless for characters that are not alphanumeric
  function automatic logic [BaseBits-1:0] digit_of(input logic [CharBits-1:0] ch);
    logic [CharBits-1:0] v;
    if (ch inside {[CharZero:CharNine]}) begin
      v = ch - CharZero;
    end else if (ch inside {[CharUpA:CharUpZ]}) begin
      v = ch - LetterUpOfs;
    end else begin
      v = ch - LetterLowOfs;
    end
    return v[BaseBits-1:0];
  endfunction

endpackage

[rtl/s2i_accum.sv]
// s2i_accum: one multiply-add step of the magnitude with the overflow test against the sign limit
// depends on s2i_pkg

module s2i_accum #(
  parameter int unsigned VALUE_BITS = s2i_pkg::ValueBitsDef
) (
  input  logic [VALUE_BITS-1:0]         acc_i,
  input  logic [s2i_pkg::BaseBits-1:0]  base_i,
  input  logic [s2i_pkg::BaseBits-1:0]  digit_i,
  input  logic                          neg_i,
  input  logic                          ovf_i,
  output logic [VALUE_BITS-1:0]         acc_o,
  output logic                          ovf_o
);

  localparam int unsigned WideBits = VALUE_BITS + s2i_pkg::BaseBits + 1;

  logic [WideBits-1:0] prod;
  logic [WideBits-1:0] sum;
  logic [WideBits-1:0] limit;

  assign prod  = WideBits'(acc_i) * WideBits'(base_i);
  assign sum   = prod + WideBits'(digit_i);
  // 2^(n-1) for a negative value, 2^(n-1) - 1 otherwise
  assign limit = (WideBits'(1) << (VALUE_BITS - 1)) - WideBits'(!neg_i);

  assign ovf_o = ovf_i || (sum > limit);
  assign acc_o = ovf_o ? acc_i : sum[VALUE_BITS-1:0];

endmodule

[rtl/s2i_core.sv]
// s2i_core: parse state registers and the per-character next-state and result logic
// depends on s2i_pkg and s2i_accum

module s2i_core #(
  parameter int unsigned VALUE_BITS    = s2i_pkg::ValueBitsDef,
  parameter int unsigned POSITION_BITS = s2i_pkg::PositionBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [s2i_pkg::CharBits-1:0]  char_i,
  input  logic [s2i_pkg::BaseBits-1:0]  cfg_base_i,
  output logic                          emit_o,
  output logic [VALUE_BITS-1:0]         value_o,
  output logic [POSITION_BITS-1:0]      offset_o,
  output logic                          ovf_o
);

  s2i_pkg::phase_e                phase_q, phase_d;
  logic                           neg_q, neg_d;
  logic [s2i_pkg::BaseBits-1:0]   base_q, base_d;
  logic [VALUE_BITS-1:0]          acc_q, acc_d;
  logic                           seen_q, seen_d;
  logic                           ovf_q, ovf_d;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;

  logic [s2i_pkg::BaseBits-1:0]   eff_base;
  logic [s2i_pkg::BaseBits-1:0]   digit;
  logic                           digit_ok;
  logic [VALUE_BITS-1:0]          acc_next;
  logic                           ovf_next;
  logic [VALUE_BITS-1:0]          half;

  assign digit = s2i_pkg::digit_of(char_i);
  assign half  = VALUE_BITS'(1) << (VALUE_BITS - 1);

  s2i_accum #(
    .VALUE_BITS(VALUE_BITS)
  ) u_s2i_accum (
    .acc_i   (acc_q),
    .base_i  (eff_base),
    .digit_i (digit),
    .neg_i   (neg_q),
    .ovf_i   (ovf_q),
    .acc_o   (acc_next),
    .ovf_o   (ovf_next)
  );

  always_comb begin
    logic go_signed;
    logic go_zero;
    logic go_digits;
    logic adv;
    logic seen_now;

    phase_d   = phase_q;
    neg_d     = neg_q;
    base_d    = base_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    pos_d     = pos_q;
    eff_base  = base_q;
    emit_o    = 1'b0;
    digit_ok  = 1'b0;
    go_signed = 1'b0;
    go_zero   = 1'b0;
    go_digits = 1'b0;
    adv       = 1'b0;
    seen_now  = seen_q;

    case (phase_q)
      s2i_pkg::PhSpace: begin
        if (s2i_pkg::is_space(char_i)) begin
          adv = 1'b1;
        end else begin
          eff_base = cfg_base_i;
          if (char_i == s2i_pkg::CharMinus || char_i == s2i_pkg::CharPlus) begin
            neg_d   = (char_i == s2i_pkg::CharMinus);
            phase_d = s2i_pkg::PhSigned;
            adv     = 1'b1;
          end else begin
            go_signed = 1'b1;
          end
        end
      end
      s2i_pkg::PhSigned: go_signed = 1'b1;
      s2i_pkg::PhZero:   go_zero   = 1'b1;
      s2i_pkg::PhDigits: go_digits = 1'b1;
      default:           go_digits = 1'b1;
    endcase

    // after the sign: a leading zero may open a prefix
    if (go_signed) begin
      if (char_i == s2i_pkg::CharZero) begin
        phase_d = s2i_pkg::PhZero;
        adv     = 1'b1;
      end else begin
        if (eff_base == s2i_pkg::BaseAuto) begin
          eff_base = s2i_pkg::BaseDec;
        end
        go_digits = 1'b1;
      end
    end

    // after the leading zero: radix prefix, or the zero counts as a digit
    if (go_zero) begin
      if ((eff_base == s2i_pkg::BaseAuto || eff_base == s2i_pkg::BaseHex) &&
          (char_i == s2i_pkg::CharLowX || char_i == s2i_pkg::CharUpX)) begin
        eff_base = s2i_pkg::BaseHex;
        phase_d  = s2i_pkg::PhDigits;
        adv      = 1'b1;
      end else if ((eff_base == s2i_pkg::BaseAuto || eff_base == s2i_pkg::BaseBin) &&
                   (char_i == s2i_pkg::CharLowB || char_i == s2i_pkg::CharUpB)) begin
        eff_base = s2i_pkg::BaseBin;
        phase_d  = s2i_pkg::PhDigits;
        adv      = 1'b1;
      end else begin
        if (eff_base == s2i_pkg::BaseAuto) begin
          eff_base = s2i_pkg::BaseOct;
        end
        // magnitude is still zero, so only the seen flag changes
        seen_now  = 1'b1;
        go_digits = 1'b1;
      end
    end

    if (go_digits) begin
      phase_d  = s2i_pkg::PhDigits;
      digit_ok = s2i_pkg::is_alnum(char_i) && (eff_base != s2i_pkg::BaseAuto) &&
                 (digit < eff_base);
      if (digit_ok) begin
        acc_d    = acc_next;
        ovf_d    = ovf_next;
        seen_now = 1'b1;
        adv      = 1'b1;
      end else begin
        emit_o = 1'b1;
      end
    end

    base_d = eff_base;
    seen_d = seen_now;
    if (adv && (pos_q != '1)) begin
      pos_d = pos_q + 1'b1;
    end

    // string ends: back to whitespace skipping
    if (emit_o) begin
      phase_d = s2i_pkg::PhSpace;
      neg_d   = 1'b0;
      base_d  = s2i_pkg::BaseAuto;
      acc_d   = '0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
      pos_d   = '0;
    end

    if (ovf_q) begin
      value_o = neg_q ? half : (half - 1'b1);
    end else begin
      value_o = neg_q ? ('0 - acc_q) : acc_q;
    end
    offset_o = seen_now ? pos_q : '0;
  end

  assign ovf_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= s2i_pkg::PhSpace;
      neg_q   <= 1'b0;
      base_q  <= s2i_pkg::BaseAuto;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[rtl/string_to_integer_parser.sv]
// string_to_integer_parser: top level with input register, parse core and result register
// depends on s2i_pkg and s2i_core
//
// usage
//   input channel: one character per transfer (char_code_i, in_valid_i / in_ready_o)
//   output channel: one result per ending character (parsed_value_o, end_offset_o,
//     overflowed_o, out_valid_o / out_ready_i)
//   radix register: number_base_i written at any edge with number_base_we_i high;
//     0 selects auto-detection, sampled on the first non-whitespace character
//   order: a character is taken into the input register and parsed there; an ending
//     character's result is then written into the output register, which raises
//     out_valid_o
//   throughput: one character per cycle unless stalled as below, set by the single
//     multiply-add step (magnitude * radix + digit) between the input and result registers
//   characters that produce no result never wait on the output side
//   stall: when a result waits in the output register and the receiver holds
//     out_ready_i low, characters that end no string are still taken and parsed;
//     the next ending character holds in the input register and in_ready_o drops
//     until the waiting result is transferred
//   reset: clears both valid flags, the parse state and the radix register to 0

module string_to_integer_parser #(
  parameter int unsigned VALUE_BITS    = s2i_pkg::ValueBitsDef,
  parameter int unsigned POSITION_BITS = s2i_pkg::PositionBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // radix register
  input  logic                          number_base_we_i,
  input  logic [s2i_pkg::BaseBits-1:0]  number_base_i,
  // character input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [s2i_pkg::CharBits-1:0]  char_code_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_BITS-1:0]  parsed_value_o,
  output logic [POSITION_BITS-1:0]      end_offset_o,
  output logic                          overflowed_o
);

  logic [s2i_pkg::BaseBits-1:0]  base_cfg_q;

  // input register
  logic                          in_valid_q;
  logic [s2i_pkg::CharBits-1:0]  char_q;

  // result register
  logic                          out_valid_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic [POSITION_BITS-1:0]      offset_q;
  logic                          ovf_q;

  logic                          emit;
  logic [VALUE_BITS-1:0]         core_value;
  logic [POSITION_BITS-1:0]      core_offset;
  logic                          core_ovf;
  logic                          out_free;
  logic                          step;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;
  // the buffered character is parsed unless its result has nowhere to go
  assign step     = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || step;

  s2i_core #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_s2i_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_i     (char_q),
    .cfg_base_i (base_cfg_q),
    .emit_o     (emit),
    .value_o    (core_value),
    .offset_o   (core_offset),
    .ovf_o      (core_ovf)
  );

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q <= s2i_pkg::BaseAuto;
    end else if (number_base_we_i) begin
      base_cfg_q <= number_base_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && emit;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      value_q  <= core_value;
      offset_q <= core_offset;
      ovf_q    <= core_ovf;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = $signed(value_q);
  assign end_offset_o   = offset_q;
  assign overflowed_o   = ovf_q;

endmodule

[rtl/s2i_chk.sv]
// s2i_chk: port-level assertions for the string to integer parser, bound to the top level
// depends on string_to_integer_parser

module s2i_chk #(
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [VALUE_BITS-1:0]  parsed_value_o,
  input logic [POSITION_BITS-1:0]      end_offset_o,
  input logic                          overflowed_o
);

  localparam logic [VALUE_BITS-1:0] ValMin = VALUE_BITS'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] ValMax = ValMin - 1'b1;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(parsed_value_o) &&
    $stable(end_offset_o) && $stable(overflowed_o))
    else $error("stalled result changed");

  // overflow always saturates
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |->
    (VALUE_BITS'(parsed_value_o) == ValMin) || (VALUE_BITS'(parsed_value_o) == ValMax))
    else $error("overflow without saturated value");

  // no digits means zero value and no overflow
  a_no_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (end_offset_o == '0) |-> (parsed_value_o == '0) && !overflowed_o)
    else $error("empty conversion with nonzero value");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // reset leaves no result behind
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind string_to_integer_parser s2i_chk #(
  .VALUE_BITS    (VALUE_BITS),
  .POSITION_BITS (POSITION_BITS)
) u_s2i_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .parsed_value_o (parsed_value_o),
  .end_offset_o   (end_offset_o),
  .overflowed_o   (overflowed_o)
);

[verif/string_to_integer_parser_test.sv]
// string_to_integer_parser_test: self-checking bench for the string to integer parser
// depends on s2i_pkg and the string_to_integer_parser rtl; reads no files, needs no arguments
`timescale 1ns / 100ps

module string_to_integer_parser_test;
  import s2i_pkg::*;

  localparam int unsigned VB = ValueBitsDef;
  localparam int unsigned PB = PositionBitsDef;

  // saturation values and the offset ceiling
  localparam logic signed [VB-1:0] ValMax = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] ValMin = {1'b1, {(VB-1){1'b0}}};
  localparam logic [PB-1:0] PosMax = '1;

  // radix settings beyond the named ones in the package
  localparam logic [BaseBits-1:0] RadixUnary = 6'd1;
  localparam logic [BaseBits-1:0] RadixTop   = 6'd36;
  localparam logic [BaseBits-1:0] RadixOver  = 6'd37;
  localparam logic [BaseBits-1:0] RadixAll   = 6'd63;
  localparam logic [BaseBits-1:0] RadixSweep [9] = '{BaseAuto, RadixAll, RadixUnary, BaseBin,
                                                     BaseOct, BaseDec, BaseHex, RadixTop,
                                                     RadixOver};

  localparam int unsigned QuietLimit = 5000;  // cycles without any transfer before giving up
  localparam int unsigned HoldCycles = 400;   // long receiver hold-off
  localparam int unsigned SettleCycles = 4;   // lets the input register, the parse and the result register drain

  typedef struct packed {
    logic signed [VB-1:0] value;
    logic [PB-1:0]        offset;
    logic                 ovf;
  } parse_out_t;

  // one directed string: optional radix write, body, ending character, optional typed result
  typedef struct {
    bit                   set_base;
    logic [BaseBits-1:0]  base;
    string                text;
    logic [CharBits-1:0]  tail;
    bit                   typed;
    parse_out_t           want;
  } plan_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         number_base_we_i;
  logic [BaseBits-1:0]          number_base_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [CharBits-1:0]          char_code_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [VB-1:0]         parsed_value_o;
  logic [PB-1:0]                end_offset_o;
  logic                         overflowed_o;

  string_to_integer_parser #(
    .VALUE_BITS    (VB),
    .POSITION_BITS (PB)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .number_base_we_i (number_base_we_i),
    .number_base_i    (number_base_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .parsed_value_o   (parsed_value_o),
    .end_offset_o     (end_offset_o),
    .overflowed_o     (overflowed_o)
  );

  always #10 clk_i = ~clk_i;

  // results still owed by the parser, oldest first
  parse_out_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned sent_chars = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;       // random gaps on both sides
  bit hold_pending = 1'b0;  // asks the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // parser shadow: radix register plus the state of the string in progress
  // ---------------------------------------------------------------------------
  logic [BaseBits-1:0] base_reg;
  phase_e              str_phase;
  logic                str_neg;
  logic [BaseBits-1:0] str_radix;     // radix latched for this string
  logic [VB-1:0]       str_mag;
  logic                str_has_digit;
  logic                str_sat;
  logic [PB-1:0]       str_pos;

  function automatic void restart_string();
    str_phase     = PhSpace;
    str_neg       = 1'b0;
    str_radix     = BaseAuto;
    str_mag       = '0;
    str_has_digit = 1'b0;
    str_sat       = 1'b0;
    str_pos       = '0;
  endfunction

  // offset stops at the top rather than wrapping
  function automatic void bump_pos();
    if (str_pos != PosMax) begin
      str_pos = str_pos + 1'b1;
    end
  endfunction

  // 0 to 35 for alphanumerics, all ones for anything else
  function automatic logic [CharBits-1:0] char_weight(input logic [CharBits-1:0] c);
    if (c >= CharZero && c <= CharNine) begin
      return c - CharZero;
    end
    if (c >= CharUpA && c <= CharUpZ) begin
      return c - CharUpA + 8'd10;
    end
    if (c >= CharLowA && c <= CharLowZ) begin
      return c - CharLowA + 8'd10;
    end
    return 8'hFF;
  endfunction

  // widened multiply-add against the limit for the sign; once saturated the magnitude freezes
  function automatic void add_digit(input logic [CharBits-1:0] d);
    logic [63:0] lim;
    logic [63:0] nxt;
    lim = (64'd1 << (VB - 1)) - (str_neg ? 64'd0 : 64'd1);
    nxt = 64'(str_mag) * 64'(str_radix) + 64'(d);
    if (str_sat || nxt > lim) begin
      str_sat = 1'b1;
    end else begin
      str_mag = nxt[VB-1:0];
    end
    str_has_digit = 1'b1;
  endfunction

  // advances the shadow by one character; returns 1 when the character ends a string
  function automatic bit parse_char(input logic [CharBits-1:0] c, output parse_out_t r);
    logic [CharBits-1:0] w;
    r = '0;
    if (str_phase == PhSpace) begin
      if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
        bump_pos();
        return 1'b0;
      end
      // radix is latched on the first non-blank character
      str_radix = base_reg;
      if (c == CharMinus || c == CharPlus) begin
        str_neg   = (c == CharMinus);
        str_phase = PhSigned;
        bump_pos();
        return 1'b0;
      end
      str_phase = PhSigned;
    end

    if (str_phase == PhSigned) begin
      if (c == CharZero) begin
        str_phase = PhZero;
        bump_pos();
        return 1'b0;
      end
      if (str_radix == BaseAuto) begin
        str_radix = BaseDec;
      end
      str_phase = PhDigits;
    end else if (str_phase == PhZero) begin
      if ((str_radix == BaseAuto || str_radix == BaseHex) && (c == CharLowX || c == CharUpX)) begin
        str_radix = BaseHex;
        str_phase = PhDigits;
        bump_pos();
        return 1'b0;
      end
      if ((str_radix == BaseAuto || str_radix == BaseBin) && (c == CharLowB || c == CharUpB)) begin
        str_radix = BaseBin;
        str_phase = PhDigits;
        bump_pos();
        return 1'b0;
      end
      if (str_radix == BaseAuto) begin
        str_radix = BaseOct;
      end
      // the leading zero was a digit after all
      add_digit(8'd0);
      str_phase = PhDigits;
    end

    w = char_weight(c);
    if (str_radix != BaseAuto && w < 8'(str_radix)) begin
      add_digit(w);
      bump_pos();
      return 1'b0;
    end

    if (str_sat) begin
      r.value = str_neg ? ValMin : ValMax;
    end else begin
      r.value = str_neg ? -str_mag : str_mag;
    end
    r.offset = str_has_digit ? str_pos : '0;
    r.ovf    = str_sat;
    restart_string();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one character transfer; the expectation is the typed one where given, else the shadow's
  task automatic push_char(input logic [CharBits-1:0] c, input bit typed = 1'b0,
                           input parse_out_t want = '0);
    parse_out_t got;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sent_chars++;
    if (parse_char(c, got)) begin
      expected_results.push_back(typed ? want : got);
    end
  endtask

  // digit character for a value, letters in either case
  function automatic logic [CharBits-1:0] digit_char(input int unsigned v);
    if (v < 10) begin
      return CharZero + 8'(v);
    end
    return ($urandom_range(0, 1) ? CharUpA : CharLowA) + 8'(v - 10);
  endfunction

  // stop feeding, let every owed result out, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_radix(input logic [BaseBits-1:0] b);
    number_base_i    <= b;
    number_base_we_i <= 1'b1;
    @(posedge clk_i);
    number_base_we_i <= 1'b0;
    base_reg = b;
  endtask

  // a plausible number for the current radix: blanks, sign, prefix, digits, terminator
  task automatic send_number();
    int unsigned eff;
    int unsigned kind;
    logic [63:0] v;
    logic [CharBits-1:0] digs [$];
    repeat ($urandom_range(0, 2)) begin
      push_char(($urandom_range(0, 5) == 0) ? CharSpace : 8'($urandom_range(9, 13)));
    end
    case ($urandom_range(0, 3))
      0: push_char(CharMinus);
      1: push_char(CharPlus);
      default: ;
    endcase

    eff = (base_reg > RadixTop) ? RadixTop : base_reg;
    if (base_reg == BaseAuto || base_reg == BaseHex || base_reg == BaseBin) begin
      kind = $urandom_range(0, 3);
      if (kind == 0 && base_reg != BaseBin) begin
        push_char(CharZero);
        push_char($urandom_range(0, 1) ? CharLowX : CharUpX);
        eff = BaseHex;
      end else if (kind == 1 && base_reg != BaseHex) begin
        push_char(CharZero);
        push_char($urandom_range(0, 1) ? CharLowB : CharUpB);
        eff = BaseBin;
      end else if (kind == 2 && base_reg == BaseAuto) begin
        push_char(CharZero);
        eff = BaseOct;
      end else if (base_reg == BaseAuto) begin
        eff = BaseDec;
      end
    end

    kind = $urandom_range(0, 9);
    if (kind == 0 && eff > 1) begin
      // a few values either side of the signed limit, written out in this radix
      v = (64'd1 << (VB - 1)) - 64'd3 + 64'($urandom_range(0, 5));
      while (v != 0) begin
        digs.push_front(digit_char(int'(v % eff)));
        v = v / eff;
      end
    end else begin
      // mostly short, sometimes empty, sometimes long enough to overflow
      repeat ((kind == 1) ? $urandom_range(0, 2) :
              (kind == 2) ? $urandom_range(9, 40) : $urandom_range(1, 8)) begin
        digs.push_back(digit_char($urandom_range(0, eff - 1)));
      end
    end
    foreach (digs[i]) push_char(digs[i]);

    case ($urandom_range(0, 4))
      0: push_char(8'h00);
      1: push_char(CharSpace);
      2: push_char(8'hFF);
      default: push_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random ready bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        span = HoldCycles;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        span = $urandom_range(1, 15);
      end else begin
        out_ready_i <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // result checker: every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    parse_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: parsed_value %0d end_offset %0d overflowed %0b",
               parsed_value_o, end_offset_o, overflowed_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (parsed_value_o !== want.value) begin
          $error("parsed_value: expected %0d, got %0d", want.value, parsed_value_o);
          mismatches++;
        end
        if (end_offset_o !== want.offset) begin
          $error("end_offset: expected %0d, got %0d", want.offset, end_offset_o);
          mismatches++;
        end
        if (overflowed_o !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, overflowed_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("** string_to_integer_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [8];
    int unsigned rand_goal;
    int unsigned target;
    int unsigned ph;
    logic [BaseBits-1:0] pick;

    rst_ni           = 1'b0;
    number_base_we_i = 1'b0;
    number_base_i    = '0;
    in_valid_i       = 1'b0;
    char_code_i      = '0;
    base_reg         = BaseAuto;
    restart_string();

    // directed strings; typed results where they are obvious
    // lone nul straight after reset, radix still auto
    plan[0] = '{1'b0, BaseAuto, "", 8'h00, 1'b1, '{'0, '0, 1'b0}};
    // largest positive value, ended by 0xff
    plan[1] = '{1'b1, RadixTop, "zik0zj", 8'hFF, 1'b1, '{ValMax, PB'(6), 1'b0}};
    // most negative value, then one more digit: saturates and keeps consuming
    plan[2] = '{1'b0, RadixTop, "-zik0zkz", ".", 1'b1, '{ValMin, PB'(8), 1'b1}};
    // bare hex prefix
    plan[3] = '{1'b1, BaseAuto, "0X", "g", 1'b1, '{'0, '0, 1'b0}};
    // sign followed by a blank, which is not skipped
    plan[4] = '{1'b0, BaseAuto, "\t-", " ", 1'b1, '{'0, '0, 1'b0}};
    // binary prefix not allowed in radix 10: the zero is a digit, the letter ends it
    plan[5] = '{1'b1, BaseDec, "0", "b", 1'b1, '{'0, PB'(1), 1'b0}};
    // radix 1: only zero is a digit
    plan[6] = '{1'b1, RadixUnary, "0", "1", 1'b1, '{'0, PB'(1), 1'b0}};
    // radix above 36: every letter counts
    plan[7] = '{1'b1, RadixAll, "Zz", "!", 1'b0, '0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].set_base) begin
        wait_idle();
        set_radix(plan[i].base);
      end
      for (int k = 0; k < plan[i].text.len(); k++) begin
        push_char(plan[i].text[k]);
      end
      push_char(plan[i].tail, plan[i].typed, plan[i].want);
    end

    // random phases, each under one radix setting; a phase may stop mid-string so the
    // next radix write lands while a string is open
    rand_goal = sent_chars + 1800;
    ph = 0;
    while (sent_chars < rand_goal) begin
      wait_idle();
      if (ph < 9) begin
        pick = RadixSweep[ph];
      end else if ($urandom_range(0, 2) == 0) begin
        pick = RadixSweep[$urandom_range(0, 8)];
      end else begin
        pick = 6'($urandom_range(0, 63));
      end
      set_radix(pick);
      // gaps in most phases, none towards the end
      idle_on = (sent_chars + 250 < rand_goal) && ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        hold_pending = 1'b1;
      end
      target = sent_chars + $urandom_range(60, 200);
      while (sent_chars < target && sent_chars < rand_goal) begin
        if (sent_chars + 250 >= rand_goal) begin
          idle_on = 1'b0;
        end
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
        end else begin
          send_number();
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        push_char($urandom_range(0, 1) ? CharPlus : CharMinus);
        push_char(CharZero);
      end
      ph++;
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles * 3) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** string_to_integer_parser: PASSED **");
    end else begin
      $display("** string_to_integer_parser: FAILED **");
    end
    $finish;
  end

endmodule
